@@ hdl/rsi_pkg.sv @@
// Shared register indexes and control types for the ray-sphere intersection block.
package rsi_pkg;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_CENTER_X = 2'd0;
    localparam t_reg_idx REG_CENTER_Y = 2'd1;
    localparam t_reg_idx REG_CENTER_Z = 2'd2;
    localparam t_reg_idx REG_RADIUS   = 2'd3;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_flags;

endpackage

@@ hdl/rsi_delay.sv @@
// Fixed-depth shift register that carries side data along the pipeline.
module rsi_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        r_sr[0] <= i_data;
        for (int i = 1; i < DEPTH; i++) begin
            r_sr[i] <= r_sr[i-1];
        end
    end

    assign o_data = r_sr[DEPTH-1];

endmodule

@@ hdl/rsi_umul.sv @@
// Two-stage unsigned multiplier split into four half-width partial products.
module rsi_umul #(
    parameter int XW = 32,
    parameter int YW = 32
) (
    input  logic             i_clk,
    input  logic [XW-1:0]    i_x,
    input  logic [YW-1:0]    i_y,
    output logic [XW+YW-1:0] o_p
);

    localparam int XL = (XW + 1) / 2;
    localparam int XH = XW - XL;
    localparam int YL = (YW + 1) / 2;
    localparam int YH = YW - YL;
    localparam int PW = XW + YW;

    logic [XL+YL-1:0] r_ll;
    logic [XL+YH-1:0] r_lh;
    logic [XH+YL-1:0] r_hl;
    logic [XH+YH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        r_ll <= (XL+YL)'(i_x[XL-1:0]) * (XL+YL)'(i_y[YL-1:0]);
        r_lh <= (XL+YH)'(i_x[XL-1:0]) * (XL+YH)'(i_y[YW-1:YL]);
        r_hl <= (XH+YL)'(i_x[XW-1:XL]) * (XH+YL)'(i_y[YL-1:0]);
        r_hh <= (XH+YH)'(i_x[XW-1:XL]) * (XH+YH)'(i_y[YW-1:YL]);
        r_p  <= PW'(r_ll) + (PW'(r_lh) << YL) + (PW'(r_hl) << XL)
              + (PW'(r_hh) << (XL + YL));
    end

    assign o_p = r_p;

endmodule

@@ hdl/rsi_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, rounded down.
module rsi_sqrt #(
    parameter int DW = 134
) (
    input  logic            i_clk,
    input  logic [DW-1:0]   i_disc,
    output logic [DW/2-1:0] o_root
);

    localparam int SW = DW / 2;

    logic [DW-1:0] r_x    [SW];
    logic [SW:0]   r_rem  [SW];
    logic [SW-1:0] r_root [SW];
    logic [DW-1:0] n_x    [SW];
    logic [SW:0]   n_rem  [SW];
    logic [SW-1:0] n_root [SW];
    logic [SW+2:0] w_cur  [SW];
    logic [SW+2:0] w_trl  [SW];
    logic [SW+2:0] w_dif  [SW];
    logic [DW-1:0] w_xin  [SW];
    logic [SW:0]   w_rin  [SW];
    logic [SW-1:0] w_qin  [SW];

    always_comb begin
        for (int s = 0; s < SW; s++) begin
            if (s == 0) begin
                w_xin[s] = i_disc;
                w_rin[s] = '0;
                w_qin[s] = '0;
            end else begin
                w_xin[s] = r_x[s-1];
                w_rin[s] = r_rem[s-1];
                w_qin[s] = r_root[s-1];
            end
            w_cur[s] = {w_rin[s], w_xin[s][DW-1:DW-2]};
            w_trl[s] = {1'b0, w_qin[s], 2'b01};
            w_dif[s] = w_cur[s] - w_trl[s];
            n_x[s]   = w_xin[s] << 2;
            if (w_cur[s] >= w_trl[s]) begin
                n_rem[s]  = w_dif[s][SW:0];
                n_root[s] = {w_qin[s][SW-2:0], 1'b1};
            end else begin
                n_rem[s]  = w_cur[s][SW:0];
                n_root[s] = {w_qin[s][SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_root = r_root[SW-1];

endmodule

@@ hdl/rsi_div.sv @@
// Pipelined restoring divider for (n << FRAC_BITS) / a with overflow detect.
module rsi_div #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int NB = 68,
    parameter int AW = 64
) (
    input  logic          i_clk,
    input  logic [NB-1:0] i_n,
    input  logic [AW-1:0] i_a,
    output logic [W-2:0]  o_q,
    output logic          o_ovf
);

    localparam int NW = NB + F;
    localparam int CW = NB + F + W;

    logic [NW-1:0] r_rem [W];
    logic [AW-1:0] r_dv  [W];
    logic [W-2:0]  r_q   [W];
    logic          r_ovf [W];
    logic [NW-1:0] n_rem [W];
    logic [AW-1:0] n_dv  [W];
    logic [W-2:0]  n_q   [W];
    logic          n_ovf [W];
    logic [CW-1:0] w_sub [W];
    logic [CW-1:0] w_num;

    always_comb begin
        w_num = CW'({i_n, {F{1'b0}}});
        for (int s = 0; s < W; s++) begin
            if (s == 0) begin
                // quotient fits in W-1 bits unless n << F reaches a << (W-1)
                w_sub[s] = CW'(i_a) << (W - 1);
                n_ovf[s] = w_num >= w_sub[s];
                n_rem[s] = w_num[NW-1:0];
                n_dv[s]  = i_a;
                n_q[s]   = '0;
            end else begin
                w_sub[s] = CW'(r_dv[s-1]) << (W - 1 - s);
                n_ovf[s] = r_ovf[s-1];
                n_dv[s]  = r_dv[s-1];
                n_q[s]   = r_q[s-1];
                if (CW'(r_rem[s-1]) >= w_sub[s]) begin
                    n_rem[s] = r_rem[s-1] - w_sub[s][NW-1:0];
                    n_q[s][W-1-s] = 1'b1;
                end else begin
                    n_rem[s] = r_rem[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dv  <= n_dv;
        r_q   <= n_q;
        r_ovf <= n_ovf;
    end

    assign o_q   = r_q[W-1];
    assign o_ovf = r_ovf[W-1];

endmodule

@@ hdl/ray_sphere_intersect_top.sv @@
// Ray-sphere intersection top level: quadratic setup, root, divide, normal.
// Throughput: one ray per cycle; o_busy stays low, every stage advances each cycle.
// Depth is set by the square root (one root bit per stage) and the divider
// (one quotient bit per stage). Results strobe o_valid for one cycle.
// Synchronous active-low reset clears the valid pipeline and center; radius = 1.0.
module ray_sphere_intersect_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  rsi_pkg::t_reg_idx            i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [DATA_WIDTH-1:0] i_origin_x,
    input  logic signed [DATA_WIDTH-1:0] i_origin_y,
    input  logic signed [DATA_WIDTH-1:0] i_origin_z,
    input  logic signed [DATA_WIDTH-1:0] i_dir_x,
    input  logic signed [DATA_WIDTH-1:0] i_dir_y,
    input  logic signed [DATA_WIDTH-1:0] i_dir_z,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_hit_distance,
    output logic signed [DATA_WIDTH-1:0] o_normal_x,
    output logic signed [DATA_WIDTH-1:0] o_normal_y,
    output logic signed [DATA_WIDTH-1:0] o_normal_z
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int EW  = W + 1;
    localparam int AW  = 2 * W;
    localparam int HW  = 2 * W + 3;
    localparam int MW  = HW;
    localparam int DW  = 2 * MW;
    localparam int DWS = DW + 1;
    localparam int KPW = AW + MW;
    localparam int SW  = DW / 2;
    localparam int NN  = 2 * W + 5;
    localparam int NB  = 2 * W + 4;
    localparam int OW  = 2 * W + 2;
    localparam int ST  = 9 + SW + W;
    localparam int LAT = ST + 2;
    localparam int DEW = 3 * (W + EW);

    localparam logic [W-1:0] T_MISS = W'(0) - (W'(1) << F);
    localparam logic [W-1:0] T_MAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] S_MIN  = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] r_cx, r_cy, r_cz;
    logic [W-2:0]        r_rad;
    logic [LAT-1:0]      r_vld;
    logic                w_acc;

    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= (W-1)'(1) << F;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rsi_pkg::REG_CENTER_X: r_cx  <= i_cfg_data;
                    rsi_pkg::REG_CENTER_Y: r_cy  <= i_cfg_data;
                    rsi_pkg::REG_CENTER_Z: r_cz  <= i_cfg_data;
                    rsi_pkg::REG_RADIUS:   r_rad <= i_cfg_data[W-2:0];
                    default: ;
                endcase
            end
        end
    end

    // stage 1: e = o - c
    logic signed [W-1:0]  r_d1 [3];
    logic signed [EW-1:0] r_e1 [3];

    always_ff @(posedge i_clk) begin
        r_d1[0] <= i_dir_x;
        r_d1[1] <= i_dir_y;
        r_d1[2] <= i_dir_z;
        r_e1[0] <= EW'(i_origin_x) - EW'(r_cx);
        r_e1[1] <= EW'(i_origin_y) - EW'(r_cy);
        r_e1[2] <= EW'(i_origin_z) - EW'(r_cz);
    end

    // stage 2: products
    logic signed [2*W-1:0] r_pdd [3];
    logic signed [2*W:0]   r_pde [3];
    logic signed [2*W+1:0] r_pee [3];
    logic [2*W-3:0]        r_prr;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_pdd[i] <= (2*W)'(r_d1[i]) * (2*W)'(r_d1[i]);
            r_pde[i] <= (2*W+1)'(r_d1[i]) * (2*W+1)'(r_e1[i]);
            r_pee[i] <= (2*W+2)'(r_e1[i]) * (2*W+2)'(r_e1[i]);
        end
        r_prr <= (2*W-2)'(r_rad) * (2*W-2)'(r_rad);
    end

    // stage 3: a, h, k
    logic [AW-1:0]        r_a3;
    logic signed [HW-1:0] r_h3;
    logic signed [HW-1:0] r_k3;

    always_ff @(posedge i_clk) begin
        r_a3 <= AW'($unsigned(r_pdd[0])) + AW'($unsigned(r_pdd[1]))
              + AW'($unsigned(r_pdd[2]));
        r_h3 <= HW'(r_pde[0]) + HW'(r_pde[1]) + HW'(r_pde[2]);
        r_k3 <= HW'(r_pee[0]) + HW'(r_pee[1]) + HW'(r_pee[2])
              - HW'(signed'({1'b0, r_prr}));
    end

    // stage 4: magnitudes for the split multipliers
    logic [MW-1:0]        r_habs, r_kabs;
    logic [AW-1:0]        r_a4;
    logic signed [HW-1:0] r_h4;
    logic                 r_kneg4;

    always_ff @(posedge i_clk) begin
        r_habs  <= r_h3[HW-1] ? MW'(-r_h3) : MW'(r_h3);
        r_kabs  <= r_k3[HW-1] ? MW'(-r_k3) : MW'(r_k3);
        r_kneg4 <= r_k3[HW-1];
        r_a4    <= r_a3;
        r_h4    <= r_h3;
    end

    logic [DW-1:0]  w_hh;
    logic [KPW-1:0] w_ak;

    rsi_umul #(.XW(MW), .YW(MW)) u_hh (
        .i_clk (i_clk),
        .i_x   (r_habs),
        .i_y   (r_habs),
        .o_p   (w_hh)
    );

    rsi_umul #(.XW(AW), .YW(MW)) u_ak (
        .i_clk (i_clk),
        .i_x   (r_a4),
        .i_y   (r_kabs),
        .o_p   (w_ak)
    );

    logic [AW-1:0]        w_a6;
    logic signed [HW-1:0] w_h6;
    logic                 w_kneg6;

    rsi_delay #(.WIDTH(AW + HW + 1), .DEPTH(2)) u_dly6 (
        .i_clk  (i_clk),
        .i_data ({r_a4, r_h4, r_kneg4}),
        .o_data ({w_a6, w_h6, w_kneg6})
    );

    // stage 7: discriminant h*h - a*k
    logic signed [DWS-1:0] w_ds;
    logic [DW-1:0]         r_disc;
    logic [AW-1:0]         r_a7;
    logic signed [HW-1:0]  r_h7;
    logic                  r_miss7;

    always_comb begin
        if (w_kneg6) begin
            w_ds = DWS'(w_hh) + DWS'(w_ak);
        end else begin
            w_ds = DWS'(w_hh) - DWS'(w_ak);
        end
    end

    always_ff @(posedge i_clk) begin
        r_disc  <= w_ds[DW-1:0];
        r_miss7 <= (w_a6 == '0) || w_ds[DWS-1];
        r_a7    <= w_a6;
        r_h7    <= w_h6;
    end

    logic [SW-1:0] w_root;

    rsi_sqrt #(.DW(DW)) u_sqrt (
        .i_clk  (i_clk),
        .i_disc (r_disc),
        .o_root (w_root)
    );

    logic [AW-1:0]        w_a_sq;
    logic signed [HW-1:0] w_h_sq;
    logic                 w_miss_sq;

    rsi_delay #(.WIDTH(AW + HW + 1), .DEPTH(SW)) u_dly_sq (
        .i_clk  (i_clk),
        .i_data ({r_a7, r_h7, r_miss7}),
        .o_data ({w_a_sq, w_h_sq, w_miss_sq})
    );

    // pick the root: t0 if not negative, else t1 if positive
    logic signed [NN-1:0] w_nh, w_n0, w_n1, w_s;
    logic [NB-1:0]        r_n;
    logic [AW-1:0]        r_a8;
    rsi_pkg::t_flags      r_flg8;

    always_comb begin
        w_s  = NN'(signed'({1'b0, w_root}));
        w_nh = -NN'(w_h_sq);
        w_n0 = w_nh - w_s;
        w_n1 = w_nh + w_s;
    end

    always_ff @(posedge i_clk) begin
        r_a8        <= w_a_sq;
        r_flg8.miss <= w_miss_sq;
        r_flg8.hit  <= !w_n0[NN-1] || (!w_n1[NN-1] && (w_n1 != '0));
        r_n         <= !w_n0[NN-1] ? w_n0[NB-1:0] : w_n1[NB-1:0];
    end

    logic [W-2:0] w_q;
    logic         w_ovf;

    rsi_div #(.W(W), .F(F), .NB(NB), .AW(AW)) u_div (
        .i_clk (i_clk),
        .i_n   (r_n),
        .i_a   (r_a8),
        .o_q   (w_q),
        .o_ovf (w_ovf)
    );

    rsi_pkg::t_flags w_flg_dv;

    rsi_delay #(.WIDTH($bits(rsi_pkg::t_flags)), .DEPTH(W)) u_dly_dv (
        .i_clk  (i_clk),
        .i_data (r_flg8),
        .o_data (w_flg_dv)
    );

    // ray direction and e travel alongside to the normal stage
    logic [DEW-1:0]       w_de;
    logic signed [W-1:0]  w_dT [3];
    logic signed [EW-1:0] w_eT [3];

    rsi_delay #(.WIDTH(DEW), .DEPTH(ST - 1)) u_dly_de (
        .i_clk  (i_clk),
        .i_data ({r_d1[0], r_d1[1], r_d1[2], r_e1[0], r_e1[1], r_e1[2]}),
        .o_data (w_de)
    );

    assign {w_dT[0], w_dT[1], w_dT[2], w_eT[0], w_eT[1], w_eT[2]} = w_de;

    // stage T: hit distance
    logic signed [W-1:0] r_t;
    logic                r_missT;

    always_ff @(posedge i_clk) begin
        r_missT <= w_flg_dv.miss;
        if (w_flg_dv.miss || !w_flg_dv.hit) begin
            r_t <= T_MISS;
        end else if (w_ovf) begin
            r_t <= T_MAX;
        end else begin
            r_t <= {1'b0, w_q};
        end
    end

    // stage P: t * d
    logic signed [2*W-1:0] r_prod [3];
    logic signed [EW-1:0]  r_eP   [3];
    logic signed [W-1:0]   r_tP;
    logic                  r_missP;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i] <= (2*W)'(r_t) * (2*W)'(w_dT[i]);
            r_eP[i]   <= w_eT[i];
        end
        r_tP    <= r_t;
        r_missP <= r_missT;
    end

    // output stage: normal = e + (t*d >> F), saturated, zero on a miss
    logic signed [OW-1:0] w_sum [3];
    logic [W-1:0]         w_nrm [3];
    logic [W-1:0]         r_nrm [3];
    logic signed [W-1:0]  r_tO;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = OW'(r_prod[i] >>> F) + OW'(r_eP[i]);
            if ((&w_sum[i][OW-1:W-1]) || !(|w_sum[i][OW-1:W-1])) begin
                w_nrm[i] = w_sum[i][W-1:0];
            end else if (w_sum[i][OW-1]) begin
                w_nrm[i] = S_MIN;
            end else begin
                w_nrm[i] = T_MAX;
            end
            if (r_missP) begin
                w_nrm[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nrm <= w_nrm;
        r_tO  <= r_tP;
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_hit_distance = r_tO;
    assign o_normal_x     = r_nrm[0];
    assign o_normal_y     = r_nrm[1];
    assign o_normal_z     = r_nrm[2];

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the ray-sphere intersection block.
`timescale 1ns / 100ps

module tb_top;

    localparam int LATENCY   = 3 * 32 + 14;
    localparam int CYCLE_CAP = 400000;
    localparam logic signed [31:0] ONE  = 32'sd65536;
    localparam logic signed [31:0] QMAX = 32'h7fff_ffff;
    localparam logic signed [31:0] QMIN = 32'h8000_0000;

    typedef logic signed [159:0] t_wide;

    typedef struct {
        logic signed [31:0] o[3];
        logic signed [31:0] d[3];
    } t_ray;

    typedef struct {
        logic signed [31:0] t;
        logic signed [31:0] n[3];
    } t_hit;

    class hit_scoreboard;
        logic signed [31:0] ctr[3];
        logic [30:0]        radius;
        t_hit               pending[$];
        int                 errors;
        int                 hits;
        int                 misses;
        int                 behind;

        function new();
            ctr[0] = 0;
            ctr[1] = 0;
            ctr[2] = 0;
            radius = 31'd65536;
        endfunction

        function void set_reg(rsi_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                rsi_pkg::REG_CENTER_X: ctr[0] = val;
                rsi_pkg::REG_CENTER_Y: ctr[1] = val;
                rsi_pkg::REG_CENTER_Z: ctr[2] = val;
                rsi_pkg::REG_RADIUS:   radius = val[30:0];
                default: ;
            endcase
        endfunction

        function t_wide floor_sqrt(t_wide v);
            logic [159:0] rem;
            logic [159:0] res;
            logic [159:0] bitv;
            rem  = v;
            res  = 0;
            bitv = 160'd1 << 158;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic signed [31:0] clamp(t_wide v);
            if (v > t_wide'(QMAX)) return QMAX;
            if (v < t_wide'(QMIN)) return QMIN;
            return v[31:0];
        endfunction

        // Predict the result of an accepted ray and queue it.
        function void note_ray(t_ray r);
            t_wide e[3];
            t_wide dv[3];
            t_wide a, h, k, disc, s, n0, n1, num, q, t, rr;
            t_hit  x;
            bit    ahead;
            a = 0;
            h = 0;
            k = 0;
            for (int i = 0; i < 3; i++) begin
                dv[i] = r.d[i];
                e[i]  = t_wide'(r.o[i]) - t_wide'(ctr[i]);
                a += dv[i] * dv[i];
                h += dv[i] * e[i];
                k += e[i] * e[i];
            end
            rr = {129'b0, radius};
            k -= rr * rr;
            disc = h * h - a * k;
            if (a == 0 || disc < 0) begin
                x.t = -ONE;
                for (int i = 0; i < 3; i++) x.n[i] = 0;
                misses++;
            end else begin
                s     = floor_sqrt(disc);
                n0    = -h - s;
                n1    = -h + s;
                ahead = 1;
                num   = 0;
                if (n0 >= 0) num = n0;
                else if (n1 > 0) num = n1;
                else ahead = 0;
                if (ahead) begin
                    q = (num <<< 16) / a;
                    t = (q > t_wide'(QMAX)) ? t_wide'(QMAX) : q;
                    hits++;
                end else begin
                    t = -t_wide'(ONE);
                    behind++;
                end
                x.t = t[31:0];
                for (int i = 0; i < 3; i++) x.n[i] = clamp(((t * dv[i]) >>> 16) + e[i]);
            end
            pending = {pending, x};
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h, want %h", what, got, want);
            errors++;
        endtask

        task check_hit(t_hit got);
            t_hit want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", got.t, 0);
                return;
            end
            want = pending.pop_front();
            if (got.t !== want.t) report_mismatch("hit_distance", got.t, want.t);
            if (got.n[0] !== want.n[0]) report_mismatch("normal_x", got.n[0], want.n[0]);
            if (got.n[1] !== want.n[1]) report_mismatch("normal_y", got.n[1], want.n[1]);
            if (got.n[2] !== want.n[2]) report_mismatch("normal_z", got.n[2], want.n[2]);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    rsi_pkg::t_reg_idx  i_cfg_idx;
    logic [31:0]        i_cfg_data;
    logic               i_start;
    logic               o_busy;
    logic signed [31:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [31:0] i_dir_x, i_dir_y, i_dir_z;
    logic               o_valid;
    logic signed [31:0] o_hit_distance, o_normal_x, o_normal_y, o_normal_z;

    hit_scoreboard sb;
    int            cycles;
    int            rays_sent;
    bit            calm;

    ray_sphere_intersect_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_origin_z     (i_origin_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .o_valid        (o_valid),
        .o_hit_distance (o_hit_distance),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    // Sample result beats mid-cycle, away from the driving edge.
    always @(negedge i_clk) begin
        t_hit got;
        if (i_rst_n && o_valid) begin
            got.t    = o_hit_distance;
            got.n[0] = o_normal_x;
            got.n[1] = o_normal_y;
            got.n[2] = o_normal_z;
            sb.check_hit(got);
        end
    end

    task write_reg(rsi_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Drop start so the last ray is not taken again, then wait for the pipe to empty.
    task drain();
        i_start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] rad);
        drain();
        write_reg(rsi_pkg::REG_CENTER_X, cx);
        write_reg(rsi_pkg::REG_CENTER_Y, cy);
        write_reg(rsi_pkg::REG_CENTER_Z, cz);
        write_reg(rsi_pkg::REG_RADIUS, rad);
    endtask

    task send_ray(t_ray r);
        bit busy_seen;
        while (!calm && $urandom_range(99) < 33) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_origin_x <= r.o[0];
        i_origin_y <= r.o[1];
        i_origin_z <= r.o[2];
        i_dir_x    <= r.d[0];
        i_dir_y    <= r.d[1];
        i_dir_z    <= r.d[2];
        do begin
            @(negedge i_clk);
            busy_seen = o_busy;
            @(posedge i_clk);
        end while (busy_seen);
        sb.note_ray(r);
        rays_sent++;
    endtask

    function t_ray mk(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray r;
        r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
        r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
        return r;
    endfunction

    function logic signed [31:0] near(logic signed [31:0] c, int span);
        return c + $signed($urandom_range(2 * span)) - span;
    endfunction

    // Mostly rays aimed around the sphere, some fully random noise.
    function t_ray rand_ray();
        t_ray r;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(99) < 20) begin
                r.o[i] = $urandom;
                r.d[i] = $urandom;
            end else begin
                r.o[i] = near(sb.ctr[i], 8 * 65536);
                r.d[i] = $signed($urandom_range(4 * 65536)) - 2 * 65536;
            end
        end
        return r;
    endfunction

    initial begin
        sb         = new();
        cycles     = 0;
        rays_sent  = 0;
        calm       = 0;
        i_rst_n    = 0;
        i_cfg_we   = 0;
        i_cfg_idx  = rsi_pkg::REG_CENTER_X;
        i_cfg_data = 0;
        i_start    = 0;
        i_origin_x = 0; i_origin_y = 0; i_origin_z = 0;
        i_dir_x    = 0; i_dir_y    = 0; i_dir_z    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset sphere: unit radius at the origin
        send_ray(mk(-5 * 65536, 0, 0, 65536, 0, 0));            // hit from outside
        send_ray(mk(0, 0, 0, 0, 0, 65536));                     // origin inside
        send_ray(mk(5 * 65536, 0, 0, 65536, 0, 0));             // both roots behind
        send_ray(mk(-5 * 65536, 3 * 65536, 0, 65536, 0, 0));    // miss
        send_ray(mk(1, 2, 3, 0, 0, 0));                         // zero direction
        send_ray(mk(65535, 0, 0, 65536, 0, 0));                 // root just ahead
        send_ray(mk(65536, 0, 0, 65536, 0, 0));                 // grazing exit
        send_ray(mk(0, 65536, 0, 65536, 0, 0));                 // tangent
        send_ray(mk(-5 * 65536, 0, 0, 1, 0, 0));                // tiny dir, t saturates
        send_ray(mk(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX));
        send_ray(mk(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN));
        send_ray(mk(QMIN, 0, 0, QMAX, 0, 0));
        send_ray(mk(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN));
        send_ray(mk(-1, -1, -1, -1, -1, -1));
        set_sphere(QMAX, QMIN, QMAX, 32'h7fff_ffff);
        send_ray(mk(QMIN, QMAX, QMIN, QMAX, QMIN, QMAX));
        send_ray(mk(0, 0, 0, 65536, 65536, 65536));
        send_ray(mk(QMAX, QMIN, QMAX, 65536, 0, 0));
        set_sphere(QMIN, QMAX, QMIN, 0);
        send_ray(mk(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN));
        send_ray(mk(QMIN, QMAX, QMIN, 0, 0, 65536));

        // random phases over several sphere settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_sphere(0, 0, 0, 65536);
                1: set_sphere(3 * 65536, -2 * 65536, 65536, 2 * 65536);
                2: set_sphere($urandom, $urandom, $urandom, $urandom);
                3: set_sphere(-4 * 65536, 0, 7 * 65536, 0);
                4: set_sphere(QMAX, QMAX, QMIN, 32'hffff_ffff);
                5: set_sphere($urandom_range(65536 * 20) - 65536 * 10, 5, -5,
                              $urandom_range(8 * 65536));
                default: set_sphere(0, 0, 0, 65536 / 2);
            endcase
            calm = (ph == 1);
            for (int j = 0; j < 100; j++) send_ray(rand_ray());
        end
        calm = 0;
        i_start <= 1'b0;

        drain();
        $display("covered %0d rays: %0d hits, %0d misses, %0d behind the origin",
                 rays_sent, sb.hits, sb.misses, sb.behind);
        $display("sphere moved through many settings, extreme centers and radii included");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
